>>> sv/fif_pkg.sv
`default_nettype none

package fif_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;

  localparam int DATA_W = 32;
  localparam int OP_W   = 33;
  localparam int PROD_W = 64;
  localparam int ACC_W  = 52;
  localparam int ROW_W  = 4 * DATA_W;
  localparam int GAIN_W = 17;
  localparam int DLY_W  = 4;
  localparam int DT_W   = 16;
  localparam int IDX_W  = 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE          = 17'd65536;
  localparam logic [GAIN_W-1:0] SPEED_GAIN_RST    = 17'd3277;
  localparam logic [GAIN_W-1:0] POSITION_GAIN_RST = 17'd0;
  localparam logic [DLY_W-1:0]  SYNC_DELAY_RST    = 4'd5;

  // 20 ms in Q0.16 seconds
  localparam logic signed [OP_W-1:0] FLOW_DT_Q16 = 33'sd1311;

  typedef enum logic [IDX_W-1:0] {
    REG_SPEED_GAIN    = 2'd0,
    REG_POSITION_GAIN = 2'd1,
    REG_SYNC_DELAY    = 2'd2
  } fif_reg_t;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_AD   = 10'b0000000010,
    ST_RH   = 10'b0000000100,
    ST_DD   = 10'b0000001000,
    ST_FP   = 10'b0000010000,
    ST_SD   = 10'b0000100000,
    ST_SE   = 10'b0001000000,
    ST_PE   = 10'b0010000000,
    ST_ACC  = 10'b0100000000,
    ST_FIN  = 10'b1000000000
  } fif_state_t;

  typedef struct packed {
    fif_state_t state;
    logic       load;
    logic       commit;
  } fif_step_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/fif_hist_mem.sv
`default_nettype none

module fif_hist_mem #(
  parameter int DEPTH = fif_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [fif_pkg::ROW_W-1:0]  wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [fif_pkg::ROW_W-1:0]  rd_data
);

  logic [fif_pkg::ROW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          vld;
  logic [fif_pkg::ROW_W-1:0] rd_q;
  logic                      rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // rows never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_ok <= vld[rd_addr];
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

`default_nettype wire

>>> sv/fif_lane.sv
`default_nettype none

module fif_lane (
  input  logic                                    clk,
  input  logic                                    rst,
  input  fif_pkg::fif_step_t                      step,
  input  logic                                    flow_valid,
  input  logic signed [fif_pkg::DATA_W-1:0]       rate,
  input  logic signed [fif_pkg::DATA_W-1:0]       height,
  input  logic signed [fif_pkg::OP_W-1:0]         accel,
  input  logic        [fif_pkg::DT_W-1:0]         step_time,
  input  logic        [fif_pkg::GAIN_W-1:0]       speed_gain,
  input  logic        [fif_pkg::GAIN_W-1:0]       position_gain,
  input  logic signed [fif_pkg::DATA_W-1:0]       rd_pos,
  input  logic signed [fif_pkg::DATA_W-1:0]       rd_spd,
  output logic signed [fif_pkg::DATA_W-1:0]       new_pos,
  output logic signed [fif_pkg::DATA_W-1:0]       new_spd,
  output logic signed [fif_pkg::DATA_W-1:0]       nav_pos,
  output logic signed [fif_pkg::DATA_W-1:0]       nav_speed,
  output logic signed [fif_pkg::DATA_W-1:0]       flow_pos,
  output logic signed [fif_pkg::DATA_W-1:0]       flow_speed
);

  logic signed [fif_pkg::DATA_W-1:0]   rate_q;
  logic signed [fif_pkg::DATA_W-1:0]   height_q;
  logic signed [fif_pkg::OP_W-1:0]     accel_q;
  logic        [fif_pkg::DT_W-1:0]     dt_q;
  logic                                fvalid_q;

  logic signed [fif_pkg::DATA_W-1:0]   cur_spd;
  logic signed [fif_pkg::DATA_W-1:0]   hist_pos;
  logic signed [fif_pkg::DATA_W-1:0]   hist_spd;
  logic signed [fif_pkg::OP_W-1:0]     delta;
  logic signed [fif_pkg::OP_W-1:0]     serr;
  logic signed [fif_pkg::OP_W-1:0]     perr;
  logic signed [fif_pkg::ACC_W-1:0]    pacc;
  logic signed [fif_pkg::ACC_W-1:0]    sacc;
  logic signed [fif_pkg::PROD_W-1:0]   prod;
  logic signed [fif_pkg::DATA_W-1:0]   fs;
  logic signed [fif_pkg::DATA_W-1:0]   fp;

  logic signed [fif_pkg::OP_W-1:0]     mul_a;
  logic signed [fif_pkg::OP_W-1:0]     mul_b;
  logic signed [2*fif_pkg::OP_W-1:0]   mul_p;
  logic signed [fif_pkg::OP_W-1:0]     dt_op;
  logic signed [fif_pkg::OP_W-1:0]     sg_op;
  logic signed [fif_pkg::OP_W-1:0]     pg_op;
  logic signed [fif_pkg::PROD_W-1:0]   prod_rnd16;
  logic signed [fif_pkg::ACC_W-1:0]    prod_x1;
  logic signed [fif_pkg::ACC_W-1:0]    prod_x2;

  assign dt_op = signed'({{(fif_pkg::OP_W-fif_pkg::DT_W){1'b0}}, dt_q});
  assign sg_op = signed'({{(fif_pkg::OP_W-fif_pkg::GAIN_W){1'b0}}, speed_gain});
  assign pg_op = signed'({{(fif_pkg::OP_W-fif_pkg::GAIN_W){1'b0}}, position_gain});

  always_comb begin
    unique case (step.state)
      fif_pkg::ST_AD: begin
        mul_a = accel_q;
        mul_b = dt_op;
      end
      fif_pkg::ST_RH: begin
        mul_a = fif_pkg::OP_W'(rate_q);
        mul_b = fif_pkg::OP_W'(height_q);
      end
      fif_pkg::ST_DD: begin
        mul_a = delta;
        mul_b = dt_op;
      end
      fif_pkg::ST_FP: begin
        mul_a = fif_pkg::OP_W'(fs);
        mul_b = fif_pkg::FLOW_DT_Q16;
      end
      fif_pkg::ST_SD: begin
        mul_a = fif_pkg::OP_W'(cur_spd);
        mul_b = dt_op;
      end
      fif_pkg::ST_SE: begin
        mul_a = sg_op;
        mul_b = serr;
      end
      fif_pkg::ST_PE: begin
        mul_a = pg_op;
        mul_b = perr;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p      = mul_a * mul_b;
  assign prod_rnd16 = (prod + 64'sd32768) >>> 16;
  assign prod_x1    = signed'(prod[fif_pkg::ACC_W-1:0]);
  assign prod_x2    = signed'({prod[fif_pkg::ACC_W-2:0], 1'b0});

  // accumulators carry the old value and the rounding half, so the end is a shift
  assign new_pos = fif_pkg::sat32(fif_pkg::PROD_W'(pacc >>> 17));
  assign new_spd = fif_pkg::sat32(fif_pkg::PROD_W'(sacc >>> 16));

  always_ff @(posedge clk) begin
    prod <= mul_p[fif_pkg::PROD_W-1:0];
    if (step.load) begin
      rate_q   <= rate;
      height_q <= height;
      accel_q  <= accel;
      dt_q     <= step_time;
      fvalid_q <= flow_valid;
    end
    unique case (step.state)
      fif_pkg::ST_AD: begin
        cur_spd <= rd_spd;
        pacc    <= {{(fif_pkg::ACC_W-49){rd_pos[fif_pkg::DATA_W-1]}}, rd_pos, 1'b1, 16'b0};
        sacc    <= {{(fif_pkg::ACC_W-48){rd_spd[fif_pkg::DATA_W-1]}}, rd_spd, 1'b1, 15'b0};
      end
      fif_pkg::ST_RH: begin
        hist_pos <= rd_pos;
        hist_spd <= rd_spd;
        sacc     <= sacc + prod_x1;
        delta    <= prod_rnd16[fif_pkg::OP_W-1:0];
      end
      fif_pkg::ST_FP: begin
        pacc <= pacc + prod_x1;
      end
      fif_pkg::ST_SD: begin
        serr <= fvalid_q ? fif_pkg::OP_W'(fs) - fif_pkg::OP_W'(hist_spd) : '0;
      end
      fif_pkg::ST_SE: begin
        pacc <= pacc + prod_x2;
        perr <= fvalid_q ? fif_pkg::OP_W'(fp) - fif_pkg::OP_W'(hist_pos) : '0;
      end
      fif_pkg::ST_PE: begin
        sacc <= sacc + prod_x1;
      end
      fif_pkg::ST_ACC: begin
        pacc <= pacc + prod_x2;
      end
      default: begin
      end
    endcase
    if (step.commit) begin
      nav_pos    <= new_pos;
      nav_speed  <= new_spd;
      flow_pos   <= fp;
      flow_speed <= fs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fs <= '0;
      fp <= '0;
    end else begin
      if (step.state == fif_pkg::ST_DD && fvalid_q) begin
        fs <= fif_pkg::sat32(prod_rnd16);
      end
      if (step.state == fif_pkg::ST_SD && fvalid_q) begin
        fp <= fif_pkg::sat32(fif_pkg::PROD_W'(fp) + prod_rnd16);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/fif_ctrl.sv
`default_nettype none

module fif_ctrl #(
  parameter int DEPTH = fif_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic [fif_pkg::DLY_W-1:0]     sync_delay,
  output fif_pkg::fif_step_t            step,
  output logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic                          wr_en,
  output logic [$clog2(DEPTH)-1:0]      wr_addr
);

  localparam int HW = $clog2(DEPTH);
  localparam int SW = HW + 1;

  fif_pkg::fif_state_t state;
  fif_pkg::fif_state_t state_next;

  logic [HW-1:0] head;
  logic [HW-1:0] head_next;
  logic [HW-1:0] slot;
  logic [SW-1:0] dly;
  logic [SW-1:0] kmax;
  logic [SW-1:0] k;
  logic [SW-1:0] sum;
  logic [SW-1:0] sum_wrap;
  logic          load;
  logic          commit;
  logic          out_free;

  assign in_ready = (state == fif_pkg::ST_IDLE);
  assign load     = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign commit   = (state == fif_pkg::ST_FIN) && out_free;

  assign dly      = SW'(sync_delay);
  assign kmax     = SW'(DEPTH - 1);
  assign k        = (dly > kmax) ? kmax : dly;
  assign sum      = {1'b0, head} + SW'(DEPTH) - k;
  assign sum_wrap = sum - SW'(DEPTH);
  assign slot     = (sum >= SW'(DEPTH)) ? sum_wrap[HW-1:0] : sum[HW-1:0];

  assign head_next = (head == HW'(DEPTH - 1)) ? '0 : head + 1'b1;

  // newest row while waiting, then the delayed row
  assign rd_addr = (state == fif_pkg::ST_AD) ? slot : head;
  assign wr_en   = commit;
  assign wr_addr = head_next;

  assign step.state  = state;
  assign step.load   = load;
  assign step.commit = commit;

  always_comb begin
    unique case (state)
      fif_pkg::ST_IDLE: state_next = load ? fif_pkg::ST_AD : fif_pkg::ST_IDLE;
      fif_pkg::ST_AD:   state_next = fif_pkg::ST_RH;
      fif_pkg::ST_RH:   state_next = fif_pkg::ST_DD;
      fif_pkg::ST_DD:   state_next = fif_pkg::ST_FP;
      fif_pkg::ST_FP:   state_next = fif_pkg::ST_SD;
      fif_pkg::ST_SD:   state_next = fif_pkg::ST_SE;
      fif_pkg::ST_SE:   state_next = fif_pkg::ST_PE;
      fif_pkg::ST_PE:   state_next = fif_pkg::ST_ACC;
      fif_pkg::ST_ACC:  state_next = fif_pkg::ST_FIN;
      fif_pkg::ST_FIN:  state_next = out_free ? fif_pkg::ST_IDLE : fif_pkg::ST_FIN;
      default:          state_next = fif_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fif_pkg::ST_IDLE;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        head      <= head_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("committed item not presented");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(head))
    else $error("history head moved without a commit");

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !wr_en)
    else $error("history written while taking an item");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= HW'(DEPTH - 1))
    else $error("history slot beyond ring");

endmodule

`default_nettype wire

>>> sv/flow_inertial_fusion.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// cfg      in         cfg_we                 cfg_index, cfg_data
// in       in         in_valid / in_ready    flow_valid, flow_rate_x/y, height, accel_x/y,
//                                            step_time
// out      out        out_valid / out_ready  nav_pos_a/b, nav_speed_a/b, flow_pos_a/b,
//                                            flow_speed_a/b
//
// Items go one at a time: the accept cycle, eight steps through the one 33x33
// multiplier of each axis, and a commit cycle that writes the history row.
// A new item is taken only once the previous one has committed.
// Reset clears the history row valid bits, the ring head, the flow state and
// loads the register defaults; no clearing pass is needed.
// An item is taken while the previous result waits; a stalled output holds the commit.

module flow_inertial_fusion #(
  parameter int HISTORY_DEPTH = fif_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic        [fif_pkg::IDX_W-1:0]    cfg_index,
  input  logic        [fif_pkg::GAIN_W-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                flow_valid,
  input  logic signed [fif_pkg::DATA_W-1:0]   flow_rate_x,
  input  logic signed [fif_pkg::DATA_W-1:0]   flow_rate_y,
  input  logic signed [fif_pkg::DATA_W-1:0]   height,
  input  logic signed [fif_pkg::DATA_W-1:0]   accel_x,
  input  logic signed [fif_pkg::DATA_W-1:0]   accel_y,
  input  logic        [fif_pkg::DT_W-1:0]     step_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fif_pkg::DATA_W-1:0]   nav_pos_a,
  output logic signed [fif_pkg::DATA_W-1:0]   nav_pos_b,
  output logic signed [fif_pkg::DATA_W-1:0]   nav_speed_a,
  output logic signed [fif_pkg::DATA_W-1:0]   nav_speed_b,
  output logic signed [fif_pkg::DATA_W-1:0]   flow_pos_a,
  output logic signed [fif_pkg::DATA_W-1:0]   flow_pos_b,
  output logic signed [fif_pkg::DATA_W-1:0]   flow_speed_a,
  output logic signed [fif_pkg::DATA_W-1:0]   flow_speed_b
);

  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int DW = fif_pkg::DATA_W;

  logic [fif_pkg::GAIN_W-1:0] speed_gain;
  logic [fif_pkg::GAIN_W-1:0] position_gain;
  logic [fif_pkg::DLY_W-1:0]  sync_delay;
  logic [fif_pkg::GAIN_W-1:0] sg_clamp;
  logic [fif_pkg::GAIN_W-1:0] pg_clamp;

  fif_pkg::fif_step_t        step;
  logic [HW-1:0]             rd_addr;
  logic                      wr_en;
  logic [HW-1:0]             wr_addr;
  logic [fif_pkg::ROW_W-1:0] rd_data;
  logic [fif_pkg::ROW_W-1:0] wr_data;

  logic signed [fif_pkg::OP_W-1:0] accel_a;
  logic signed [fif_pkg::OP_W-1:0] accel_b;
  logic signed [DW-1:0]            new_pos_a;
  logic signed [DW-1:0]            new_pos_b;
  logic signed [DW-1:0]            new_spd_a;
  logic signed [DW-1:0]            new_spd_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain    <= fif_pkg::SPEED_GAIN_RST;
      position_gain <= fif_pkg::POSITION_GAIN_RST;
      sync_delay    <= fif_pkg::SYNC_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fif_pkg::REG_SPEED_GAIN:    speed_gain    <= cfg_data;
        fif_pkg::REG_POSITION_GAIN: position_gain <= cfg_data;
        fif_pkg::REG_SYNC_DELAY:    sync_delay    <= cfg_data[fif_pkg::DLY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign sg_clamp = (speed_gain > fif_pkg::GAIN_ONE) ? fif_pkg::GAIN_ONE : speed_gain;
  assign pg_clamp = (position_gain > fif_pkg::GAIN_ONE) ? fif_pkg::GAIN_ONE : position_gain;

  // first axis runs on the negated x acceleration
  assign accel_a = fif_pkg::OP_W'(0) - fif_pkg::OP_W'(accel_x);
  assign accel_b = fif_pkg::OP_W'(accel_y);

  // row: pos a, pos b, speed a, speed b
  assign wr_data = {new_pos_a, new_pos_b, new_spd_a, new_spd_b};

  fif_ctrl #(
    .DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sync_delay(sync_delay),
    .step      (step),
    .rd_addr   (rd_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr)
  );

  fif_hist_mem #(
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  fif_lane u_lane_a (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .flow_valid   (flow_valid),
    .rate         (flow_rate_x),
    .height       (height),
    .accel        (accel_a),
    .step_time    (step_time),
    .speed_gain   (sg_clamp),
    .position_gain(pg_clamp),
    .rd_pos       (rd_data[4*DW-1:3*DW]),
    .rd_spd       (rd_data[2*DW-1:DW]),
    .new_pos      (new_pos_a),
    .new_spd      (new_spd_a),
    .nav_pos      (nav_pos_a),
    .nav_speed    (nav_speed_a),
    .flow_pos     (flow_pos_a),
    .flow_speed   (flow_speed_a)
  );

  fif_lane u_lane_b (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .flow_valid   (flow_valid),
    .rate         (flow_rate_y),
    .height       (height),
    .accel        (accel_b),
    .step_time    (step_time),
    .speed_gain   (sg_clamp),
    .position_gain(pg_clamp),
    .rd_pos       (rd_data[3*DW-1:2*DW]),
    .rd_spd       (rd_data[DW-1:0]),
    .new_pos      (new_pos_b),
    .new_spd      (new_spd_b),
    .nav_pos      (nav_pos_b),
    .nav_speed    (nav_speed_b),
    .flow_pos     (flow_pos_b),
    .flow_speed   (flow_speed_b)
  );

endmodule

`default_nettype wire
